@@ rtl/core/isfu_pkg.sv @@
package isfu_pkg;

  // Lane and field geometry
  localparam int unsigned LANES     = 7;
  localparam int unsigned LANE_W    = 3;
  localparam int unsigned FRAME_W   = 13;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned CLAMP_W   = 16;
  localparam int unsigned LAYOUT_W  = 28;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  localparam logic [LANE_W-1:0] LAST_LANE = 3'd6;

  // Frame queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  // Saturation bounds
  localparam logic [CLAMP_W-1:0] CLAMP_HI   = 16'h7FFF;
  localparam logic [CLAMP_W-1:0] CLAMP_LO   = 16'h8000;
  localparam logic [VALUE_W-1:0] CLAMP_HI_X = 64'h0000_0000_0000_7FFF;
  localparam logic [VALUE_W-1:0] CLAMP_LO_X = 64'hFFFF_FFFF_FFFF_8000;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_FRAME_BYTES = 3'd0,
    REG_ACCEL_X     = 3'd1,
    REG_ACCEL_Y     = 3'd2,
    REG_ACCEL_Z     = 3'd3,
    REG_GYRO_X      = 3'd4,
    REG_GYRO_Y      = 3'd5,
    REG_GYRO_Z      = 3'd6,
    REG_STAMP       = 3'd7
  } reg_idx_e;

  localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET = 13'd24;

  // Channel layout register, MSB first
  typedef struct packed {
    logic       big;
    logic       sgn;
    logic [5:0] shift;
    logic [5:0] bits_m1;
    logic [1:0] log2_size;
    logic [11:0] offset;
  } layout_t;

  typedef layout_t [LANES-1:0] layout_arr_t;

  localparam logic [LAYOUT_W-1:0] LAYOUT_RESET [LANES] = '{
    28'd201576448, 28'd201576450, 28'd201576452, 28'd201576454,
    28'd201576456, 28'd201576458, 28'd68153360
  };

  typedef logic [VALUE_W-1:0] lane_acc_t;
  typedef lane_acc_t [LANES-1:0] frame_rec_t;

  // Back end, decode stage contents
  typedef struct packed {
    logic [LANE_W-1:0]  lane;
    logic [VALUE_W-1:0] value;
    logic [5:0]         bits_m1;
    logic               sgn;
    logic               span_err;
  } dec_stage_t;

endpackage

@@ rtl/core/isfu_front.sv @@
module isfu_front #(
  parameter int unsigned PosW = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    frame_byte_i,
  input  logic [isfu_pkg::FRAME_W-1:0]  frame_len_i,
  input  isfu_pkg::layout_arr_t         layout_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output isfu_pkg::frame_rec_t          push_rec_o
);

  logic [PosW-1:0]                 pos_q, pos_d;
  isfu_pkg::frame_rec_t            acc_q, acc_d, acc_gather;
  logic [isfu_pkg::FRAME_W-1:0]    pos_ext;
  logic [isfu_pkg::FRAME_W-1:0]    lane_off  [isfu_pkg::LANES];
  logic [isfu_pkg::FRAME_W-1:0]    lane_end  [isfu_pkg::LANES];
  logic [isfu_pkg::FRAME_W-1:0]    lane_rel  [isfu_pkg::LANES];
  logic                            lane_hit  [isfu_pkg::LANES];
  logic                            frame_end;
  logic                            accept;

  assign pos_ext   = isfu_pkg::FRAME_W'(pos_q);
  assign frame_end = (pos_ext + 13'd1) >= frame_len_i;

  // Only the completing byte needs room in the queue
  assign in_ready_o   = !frame_end || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = accept && frame_end;
  assign push_rec_o   = acc_gather;

  // Per-lane byte gather under the current layout
  always_comb begin
    for (int i = 0; i < isfu_pkg::LANES; i++) begin
      lane_off[i] = {1'b0, layout_i[i].offset};
      lane_end[i] = lane_off[i] + (13'd1 << layout_i[i].log2_size);
      lane_hit[i] = (pos_ext >= lane_off[i]) && (pos_ext < lane_end[i]);
      lane_rel[i] = pos_ext - lane_off[i];
      acc_gather[i] = acc_q[i];
      if (lane_hit[i]) begin
        if (layout_i[i].big) begin
          acc_gather[i] = {acc_q[i][55:0], frame_byte_i};
        end else begin
          acc_gather[i] = acc_q[i] |
                          (64'(frame_byte_i) << {lane_rel[i][2:0], 3'b000});
        end
      end
    end
  end

  // Position counter and lane accumulators
  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (accept) begin
      if (frame_end) begin
        pos_d = '0;
        acc_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
        acc_d = acc_gather;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

@@ rtl/core/isfu_queue.sv @@
module isfu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  isfu_pkg::frame_rec_t push_rec_i,
  output logic                 head_valid_o,
  input  logic                 pop_i,
  output isfu_pkg::frame_rec_t head_rec_o
);

  isfu_pkg::frame_rec_t              mem_q [isfu_pkg::Q_DEPTH];
  logic [isfu_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [isfu_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [isfu_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign push_ready_o = cnt_q != isfu_pkg::QCNT_W'(isfu_pkg::Q_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_rec_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = wr_ptr_q + isfu_pkg::QPTR_W'(1);
    if (do_pop)  rd_ptr_d = rd_ptr_q + isfu_pkg::QPTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + isfu_pkg::QCNT_W'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - isfu_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Frame storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

@@ rtl/core/isfu_back.sv @@
module isfu_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  isfu_pkg::frame_rec_t                head_rec_i,
  output logic                                pop_o,
  input  isfu_pkg::layout_arr_t               layout_i,
  input  logic [isfu_pkg::FRAME_W-1:0]        frame_len_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [isfu_pkg::LANE_W-1:0]         channel_id_o,
  output logic signed [isfu_pkg::VALUE_W-1:0] raw_value_o,
  output logic signed [isfu_pkg::CLAMP_W-1:0] clamped_value_o,
  output logic                                decode_error_o,
  output logic                                last_of_frame_o
);

  logic [isfu_pkg::LANE_W-1:0]  lane_q, lane_d;
  isfu_pkg::layout_t            lay;
  isfu_pkg::lane_acc_t          acc_sel;
  logic [isfu_pkg::VALUE_W-1:0] mask_a;
  logic [isfu_pkg::FRAME_W-1:0] span_end;
  isfu_pkg::dec_stage_t         s1_q, s1_d;
  logic                         s1_valid_q;
  logic                         issue, s1_ready, out_take, s1_move;

  logic [isfu_pkg::VALUE_W-1:0] mask_b;
  logic [isfu_pkg::VALUE_W-1:0] val_b;
  logic                         err_b;
  logic [isfu_pkg::CLAMP_W-1:0] clamp_b;

  logic                         out_valid_q;
  logic [isfu_pkg::LANE_W-1:0]  ch_q;
  logic [isfu_pkg::VALUE_W-1:0] raw_q;
  logic [isfu_pkg::CLAMP_W-1:0] clamp_q;
  logic                         err_q;
  logic                         last_q;

  // Flow control: output register, then decode register, then issue
  assign out_take = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && out_take;
  assign s1_ready = !s1_valid_q || out_take;
  assign issue    = head_valid_i && s1_ready;
  assign pop_o    = issue && (lane_q == isfu_pkg::LAST_LANE);
  assign lane_d   = !issue ? lane_q :
                    (lane_q == isfu_pkg::LAST_LANE) ? '0 :
                    lane_q + isfu_pkg::LANE_W'(1);

  // Issue: select lane, shift, mask, check span
  always_comb begin
    lay      = layout_i[lane_q];
    acc_sel  = head_rec_i[lane_q];
    mask_a   = {isfu_pkg::VALUE_W{1'b1}} >> (6'd63 - lay.bits_m1);
    span_end = {1'b0, lay.offset} + (13'd1 << lay.log2_size);
    s1_d.lane     = lane_q;
    s1_d.value    = (acc_sel >> lay.shift) & mask_a;
    s1_d.bits_m1  = lay.bits_m1;
    s1_d.sgn      = lay.sgn;
    s1_d.span_err = span_end > frame_len_i;
  end

  // Decode: sign extension, overflow check, saturation
  always_comb begin
    mask_b = {isfu_pkg::VALUE_W{1'b1}} >> (6'd63 - s1_q.bits_m1);
    val_b  = s1_q.value;
    err_b  = 1'b0;
    if (s1_q.span_err) begin
      val_b = '0;
      err_b = 1'b1;
    end else if (s1_q.sgn && s1_q.value[s1_q.bits_m1]) begin
      val_b = s1_q.value | ~mask_b;
    end else if (s1_q.value[isfu_pkg::VALUE_W-1]) begin
      val_b = '0;
      err_b = 1'b1;
    end
    if (val_b[isfu_pkg::VALUE_W-1]) begin
      clamp_b = (val_b < isfu_pkg::CLAMP_LO_X) ? isfu_pkg::CLAMP_LO : val_b[15:0];
    end else begin
      clamp_b = (val_b > isfu_pkg::CLAMP_HI_X) ? isfu_pkg::CLAMP_HI : val_b[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lane_q <= lane_d;
      if (s1_ready) s1_valid_q  <= issue;
      if (out_take) out_valid_q <= s1_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue) s1_q <= s1_d;
    if (s1_move) begin
      ch_q    <= s1_q.lane;
      raw_q   <= val_b;
      clamp_q <= clamp_b;
      err_q   <= err_b;
      last_q  <= s1_q.lane == isfu_pkg::LAST_LANE;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_id_o    = ch_q;
  assign raw_value_o     = raw_q;
  assign clamped_value_o = clamp_q;
  assign decode_error_o  = err_q;
  assign last_of_frame_o = last_q;

endmodule

@@ rtl/core/imu_scan_frame_unpacker.sv @@
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------------------
// input    | in  | in_valid_i / in_ready_o   | frame_byte_i
// result   | out | out_valid_o / out_ready_i | channel_id_o, raw_value_o, clamped_value_o,
//          |     |                           | decode_error_o, last_of_frame_o
// config   | in  | psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// One byte is taken every cycle while the queue has room for a completing byte; a frame's
// seven results leave one per cycle while out_ready_i is not held low, set by the single
// shared decode path in the back end. The first result passes from the queue through the
// decode register and the output register. A two-frame queue parts gathering from decoding;
// the completing byte of a frame stalls only while that queue is full.
// Asynchronous active-low reset; no clearing pass, usable the cycle after reset.
module imu_scan_frame_unpacker #(
  parameter int unsigned MAX_FRAME_BYTES = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          frame_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [isfu_pkg::LANE_W-1:0]         channel_id_o,
  output logic signed [isfu_pkg::VALUE_W-1:0] raw_value_o,
  output logic signed [isfu_pkg::CLAMP_W-1:0] clamped_value_o,
  output logic                                decode_error_o,
  output logic                                last_of_frame_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [isfu_pkg::APB_AW-1:0]         paddr,
  input  logic [isfu_pkg::APB_DW-1:0]         pwdata,
  output logic [isfu_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);
  localparam logic [isfu_pkg::FRAME_W-1:0] MaxLen = isfu_pkg::FRAME_W'(MAX_FRAME_BYTES);

  logic [isfu_pkg::FRAME_W-1:0] frame_bytes_q;
  isfu_pkg::layout_arr_t        layout_q;
  logic [isfu_pkg::FRAME_W-1:0] frame_len;
  isfu_pkg::reg_idx_e           reg_idx;
  logic                         cfg_wr;

  logic                         push_valid, push_ready, head_valid, pop;
  isfu_pkg::frame_rec_t         push_rec, head_rec;

  assign pready  = 1'b1;
  assign reg_idx = isfu_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Effective frame length, clamped to 1..MAX_FRAME_BYTES
  assign frame_len = (frame_bytes_q == '0)   ? isfu_pkg::FRAME_W'(1) :
                     (frame_bytes_q > MaxLen) ? MaxLen : frame_bytes_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= isfu_pkg::FRAME_BYTES_RESET;
      for (int i = 0; i < isfu_pkg::LANES; i++) begin
        layout_q[i] <= isfu_pkg::LAYOUT_RESET[i];
      end
    end else if (cfg_wr) begin
      if (reg_idx == isfu_pkg::REG_FRAME_BYTES) begin
        frame_bytes_q <= pwdata[isfu_pkg::FRAME_W-1:0];
      end else begin
        layout_q[3'(reg_idx) - 3'd1] <= pwdata[isfu_pkg::LAYOUT_W-1:0];
      end
    end
  end

  // Register read back
  always_comb begin
    case (reg_idx)
      isfu_pkg::REG_FRAME_BYTES: prdata = isfu_pkg::APB_DW'(frame_bytes_q);
      isfu_pkg::REG_ACCEL_X:     prdata = isfu_pkg::APB_DW'(layout_q[0]);
      isfu_pkg::REG_ACCEL_Y:     prdata = isfu_pkg::APB_DW'(layout_q[1]);
      isfu_pkg::REG_ACCEL_Z:     prdata = isfu_pkg::APB_DW'(layout_q[2]);
      isfu_pkg::REG_GYRO_X:      prdata = isfu_pkg::APB_DW'(layout_q[3]);
      isfu_pkg::REG_GYRO_Y:      prdata = isfu_pkg::APB_DW'(layout_q[4]);
      isfu_pkg::REG_GYRO_Z:      prdata = isfu_pkg::APB_DW'(layout_q[5]);
      isfu_pkg::REG_STAMP:       prdata = isfu_pkg::APB_DW'(layout_q[6]);
      default:                   prdata = '0;
    endcase
  end

  isfu_front #(
    .PosW (PosW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_byte_i (frame_byte_i),
    .frame_len_i  (frame_len),
    .layout_i     (layout_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  isfu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_rec_o   (head_rec)
  );

  isfu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_rec_i      (head_rec),
    .pop_o           (pop),
    .layout_i        (layout_q),
    .frame_len_i     (frame_len),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_id_o    (channel_id_o),
    .raw_value_o     (raw_value_o),
    .clamped_value_o (clamped_value_o),
    .decode_error_o  (decode_error_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

@@ rtl/core/isfu_checker.sv @@
module isfu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [isfu_pkg::LANE_W-1:0]         channel_id_o,
  input logic signed [isfu_pkg::VALUE_W-1:0] raw_value_o,
  input logic signed [isfu_pkg::CLAMP_W-1:0] clamped_value_o,
  input logic                                decode_error_o,
  input logic                                last_of_frame_o
);

  // A stalled result request holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_id_o) &&
      $stable(raw_value_o) && $stable(clamped_value_o) && $stable(decode_error_o))
    else $error("result request dropped or changed while stalled");

  // The frame's last result is always the timestamp lane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_frame_o == (channel_id_o == isfu_pkg::LAST_LANE)))
    else $error("last_of_frame does not match channel 6");

  // Errors carry zeroed values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> raw_value_o == '0 && clamped_value_o == '0)
    else $error("error result with nonzero value");

  // In-range values pass through the clamp unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (raw_value_o[63:15] == '0 || raw_value_o[63:15] == '1)
      |-> clamped_value_o == raw_value_o[15:0])
    else $error("clamp altered an in-range value");

  // Large positive values saturate high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !raw_value_o[63] && raw_value_o[62:15] != '0
      |-> clamped_value_o == isfu_pkg::CLAMP_HI)
    else $error("positive saturation missing");

endmodule

bind imu_scan_frame_unpacker isfu_checker u_isfu_checker (.*);
